[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property holds in the same cycle as its trigger.
`define CHK_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
// Property holds in the cycle after its trigger.
`define CHK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define CHK_SAME(lbl, pre, post, msg)
`define CHK_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/akf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Altitude Kalman filter package
// Constants and fixed-point helpers shared by the filter modules.
// ----------------------------------------------------------------------------
package akf_pkg;

    // Configuration register indexes.
    localparam logic CFG_PROCESS_NOISE = 1'b0;
    localparam logic CFG_MEAS_NOISE    = 1'b1;

    // Reset values: 0.001 and 10.0 in Q8.24, and 1.0 in Q8.24.
    localparam logic [30:0] PROCESS_NOISE_RST = 31'd16777;
    localparam logic [30:0] MEAS_NOISE_RST    = 31'd167772160;
    localparam logic signed [31:0] ONE_Q24    = 32'sd16777216;

    // Operation selector carried in tuser.
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    // Product width of the shared multiplier.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef logic signed [MUL_P_W-1:0] prod_t;
    typedef logic signed [47:0] wide_t;

    // Round half up, then shift right by 24.
    function automatic logic signed [41:0] rnd24(input prod_t p);
        prod_t t;
        t = p + prod_t'(1 <<< 23);
        return 42'(t >>> 24);
    endfunction

    // Round half up, then shift right by 25.
    function automatic logic signed [40:0] rnd25(input prod_t p);
        prod_t t;
        t = p + prod_t'(1 <<< 24);
        return 41'(t >>> 25);
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > wide_t'(32'sh7fffffff)) begin
            r = 32'sh7fffffff;
        end else if (v < wide_t'(-48'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[src/akf_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 34 x 32 multiply with a registered product, one result a cycle.
// ----------------------------------------------------------------------------
module akf_mul
    import akf_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output prod_t                     prod
);

    prod_t prod_reg;

    // Product is registered before any use.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_t'(op_a) * prod_t'(op_b);
    end

    assign prod = prod_reg;

endmodule

[src/akf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain divider
// Computes num * 2^24 / den, truncated toward zero and saturated to 32 bits,
// one quotient bit a cycle.
// ----------------------------------------------------------------------------
module akf_div
    import akf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic        [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [56:0] rem_reg;
    logic [61:0] dsh_reg;
    logic [30:0] q_reg;
    logic        neg_reg;
    logic        ovf_reg;

    logic [32:0] mag;
    logic [56:0] rem_init;
    logic        ge;

    // Magnitude of the scaled numerator.
    assign mag      = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
    assign rem_init = {mag, 24'd0};
    assign ge       = {5'd0, rem_reg} >= dsh_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division datapath.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= rem_init;
            dsh_reg <= {den, 30'd0};
            q_reg   <= '0;
            neg_reg <= num[31];
            ovf_reg <= {6'd0, rem_init} >= {den, 31'd0};
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg[56:0];
            end
            q_reg   <= {q_reg[29:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Sign and saturation of the quotient.
    always_comb begin
        if (ovf_reg) begin
            quot = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (neg_reg) begin
            quot = 32'sd0 - {1'b0, q_reg};
        end else begin
            quot = {1'b0, q_reg};
        end
    end

    assign done = done_reg;

endmodule

[src/altitude_kalman_filter_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Altitude Kalman filter core
// Two-state (altitude, velocity) filter on one shared multiplier and an
// iterative gain divider under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   tdata: vertical_accel, step_time, baro_height; tuser: func
// m_*       out  tdata: altitude_out, velocity_out
// cfg_*     in   write-only noise registers
//
// A predict item runs seven sequencer steps, five of them on the shared
// multiplier, before its result enters the output register. An update is
// mostly the two 31-step gain divisions, and goes straight to the output
// register when the innovation variance is not positive. One item is worked
// at a time; a result still waiting in the output register holds the
// sequencer, and the next item is taken the cycle after it loads. Reset is synchronous on aresetn.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_core
    import akf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // vertical_accel, step_time, baro_height
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // altitude_out, velocity_out
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_wdata
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_P0   = 5'd1;
    localparam logic [4:0] ST_P1   = 5'd2;
    localparam logic [4:0] ST_P2   = 5'd3;
    localparam logic [4:0] ST_P3   = 5'd4;
    localparam logic [4:0] ST_P4   = 5'd5;
    localparam logic [4:0] ST_P5   = 5'd6;
    localparam logic [4:0] ST_P6   = 5'd7;
    localparam logic [4:0] ST_U0   = 5'd8;
    localparam logic [4:0] ST_UD0  = 5'd9;
    localparam logic [4:0] ST_UW0  = 5'd10;
    localparam logic [4:0] ST_UW1  = 5'd11;
    localparam logic [4:0] ST_U2   = 5'd12;
    localparam logic [4:0] ST_U3   = 5'd13;
    localparam logic [4:0] ST_U4   = 5'd14;
    localparam logic [4:0] ST_U5   = 5'd15;
    localparam logic [4:0] ST_U6   = 5'd16;
    localparam logic [4:0] ST_U7   = 5'd17;
    localparam logic [4:0] ST_U8   = 5'd18;
    localparam logic [4:0] ST_DONE = 5'd19;

    logic [4:0] st_reg, st_next;

    logic [30:0] q_noise_reg;
    logic [30:0] r_noise_reg;

    logic signed [31:0] x_reg, v_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] a_reg, z_reg;
    logic        [23:0] dt_reg;
    logic               func_reg;
    logic signed [32:0] ad_reg;
    logic signed [31:0] t1_reg;
    prod_t              acc_reg;
    logic        [31:0] s_reg;
    logic signed [31:0] y_reg, k0_reg, k1_reg;

    logic               m_valid_reg;
    logic        [63:0] m_data_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    prod_t                     mul_p;
    logic signed [41:0]        r24;
    logic signed [40:0]        dx;
    logic signed [33:0]        s_sum;
    logic                      s_pos;
    logic signed [31:0]        dt_s;
    logic signed [33:0]        p01_t1;

    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_quot;

    wire in_acc = s_tvalid && s_tready;

    akf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    akf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (s_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Shared arithmetic terms.
    assign dt_s   = signed'({8'd0, dt_reg});
    assign r24    = rnd24(mul_p);
    assign dx     = rnd25(acc_reg + mul_p);
    assign s_sum  = 34'(p00_reg) + signed'({3'd0, r_noise_reg});
    assign s_pos  = !s_sum[33] && (s_sum != 34'sd0);
    assign p01_t1 = (34'(p01_reg) <<< 1) + 34'(t1_reg);

    // Divider operands.
    assign div_start = (st_reg == ST_UD0) || ((st_reg == ST_UW0) && div_done);
    assign div_num   = (st_reg == ST_UD0) ? p00_reg : p10_reg;

    // Multiplier operand selection per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (st_reg)
            ST_P0: begin mul_a = 34'(a_reg);   mul_b = dt_s; end
            ST_P1: begin mul_a = 34'(v_reg);   mul_b = dt_s; end
            ST_P2: begin mul_a = 34'(ad_reg);  mul_b = dt_s; end
            ST_P3: begin mul_a = 34'(p11_reg); mul_b = dt_s; end
            ST_P5: begin mul_a = p01_t1;       mul_b = dt_s; end
            ST_U2: begin mul_a = 34'(k0_reg);  mul_b = y_reg; end
            ST_U3: begin mul_a = 34'(k1_reg);  mul_b = y_reg; end
            ST_U4: begin mul_a = 34'(k1_reg);  mul_b = p00_reg; end
            ST_U5: begin mul_a = 34'(k0_reg);  mul_b = p00_reg; end
            ST_U6: begin mul_a = 34'(k1_reg);  mul_b = p01_reg; end
            ST_U7: begin mul_a = 34'(k0_reg);  mul_b = p01_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    st_next = (s_tuser == FUNC_UPDATE) ? ST_U0 : ST_P0;
                end
            end
            ST_P0: st_next = ST_P1;
            ST_P1: st_next = ST_P2;
            ST_P2: st_next = ST_P3;
            ST_P3: st_next = ST_P4;
            ST_P4: st_next = ST_P5;
            ST_P5: st_next = ST_P6;
            ST_P6: st_next = ST_DONE;
            ST_U0: st_next = s_pos ? ST_UD0 : ST_DONE;
            ST_UD0: st_next = ST_UW0;
            ST_UW0: begin
                if (div_done) begin
                    st_next = ST_UW1;
                end
            end
            ST_UW1: begin
                if (div_done) begin
                    st_next = ST_U2;
                end
            end
            ST_U2: st_next = ST_U3;
            ST_U3: st_next = ST_U4;
            ST_U4: st_next = ST_U5;
            ST_U5: st_next = ST_U6;
            ST_U6: st_next = ST_U7;
            ST_U7: st_next = ST_U8;
            ST_U8: st_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Control, configuration and filter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            q_noise_reg <= PROCESS_NOISE_RST;
            r_noise_reg <= MEAS_NOISE_RST;
            x_reg       <= '0;
            v_reg       <= '0;
            p00_reg     <= ONE_Q24;
            p01_reg     <= '0;
            p10_reg     <= '0;
            p11_reg     <= ONE_Q24;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                if (cfg_index == CFG_PROCESS_NOISE) begin
                    q_noise_reg <= cfg_wdata;
                end else begin
                    r_noise_reg <= cfg_wdata;
                end
            end
            // The output register loads a new item or empties when taken.
            if ((st_reg == ST_DONE) && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_P3: begin
                    x_reg <= sat32(wide_t'(x_reg) + wide_t'(dx));
                    v_reg <= sat32(wide_t'(v_reg) + wide_t'(ad_reg));
                end
                ST_P6: begin
                    p00_reg <= sat32(wide_t'(p00_reg) + wide_t'(r24)
                                     + signed'({17'd0, q_noise_reg}));
                    p01_reg <= sat32(wide_t'(p01_reg) + wide_t'(t1_reg));
                    p10_reg <= sat32(wide_t'(p10_reg) + wide_t'(t1_reg));
                    p11_reg <= sat32(wide_t'(p11_reg) + signed'({17'd0, q_noise_reg}));
                end
                ST_U3: x_reg   <= sat32(wide_t'(x_reg) + wide_t'(r24));
                ST_U4: v_reg   <= sat32(wide_t'(v_reg) + wide_t'(r24));
                ST_U5: p10_reg <= sat32(wide_t'(p10_reg) - wide_t'(r24));
                ST_U6: p00_reg <= sat32(wide_t'(p00_reg) - wide_t'(r24));
                ST_U7: p11_reg <= sat32(wide_t'(p11_reg) - wide_t'(r24));
                ST_U8: p01_reg <= sat32(wide_t'(p01_reg) - wide_t'(r24));
                default: begin
                end
            endcase
        end
    end

    // Item capture and intermediate terms.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_reg    <= s_tdata[31:0];
            dt_reg   <= s_tdata[55:32];
            z_reg    <= s_tdata[87:56];
            func_reg <= s_tuser;
        end
        case (st_reg)
            ST_P1: ad_reg  <= r24[32:0];
            ST_P2: acc_reg <= mul_p <<< 1;
            ST_P4: t1_reg  <= r24[31:0];
            ST_U0: begin
                s_reg <= s_sum[31:0];
                y_reg <= sat32(wide_t'(z_reg) - wide_t'(x_reg));
            end
            ST_UW0: begin
                if (div_done) begin
                    k0_reg <= div_quot;
                end
            end
            ST_UW1: begin
                if (div_done) begin
                    k1_reg <= div_quot;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {v_reg, x_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks on the sequencer.
    `CHK_NEXT(a_busy_after_accept, in_acc, !s_tready, "ready high during an item")
    `CHK_SAME(a_div_done_waiting, div_done, (st_reg == ST_UW0) || (st_reg == ST_UW1), "stray divider done")
    `CHK_NEXT(a_path_to_done, (st_reg == ST_P6) || (st_reg == ST_U8), st_reg == ST_DONE, "step skipped result")
    `CHK_NEXT(a_branch_by_func, (st_reg == ST_P0) || (st_reg == ST_U0), $stable(func_reg), "func changed mid item")

endmodule
